// ===== hdl/tcls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcls_pkg
// Shared types and constants for the throttled CPU load sampler.
// ----------------------------------------------------------------------------
package tcls_pkg;

    localparam int TIME_W     = 64;
    localparam int INTERVAL_W = 32;
    localparam int DIVIDER_W  = 16;
    localparam int PCT_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 3 * TIME_W;
    localparam int OUT_DATA_W = 8;

    // The product delta * 100 needs 7 bits more than delta.
    localparam int PROD_W     = TIME_W + PCT_W;
    localparam int DIV_STEPS  = PCT_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [INTERVAL_W-1:0] SAMPLE_INTERVAL_RST = 32'd1000000;
    localparam logic [DIVIDER_W-1:0]  CALL_DIVIDER_RST    = 16'd1;
    localparam logic [PCT_W-1:0]      PCT_FULL            = 7'd100;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CALL_DIVIDER    = 2'd1;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DIFF   = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_MUL1   = 7'b0001000,
        S_MUL2   = 7'b0010000,
        S_DIV    = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic diff;
        logic decide;
        logic mul1;
        logic mul2;
        logic div_step;
        logic div_last;
        logic out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic go_div;
    } dp_status_t;

endpackage

// ===== hdl/tcls_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcls_ctrl
// Sequencer that steps one collect call through the datapath.
// ----------------------------------------------------------------------------
module tcls_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output tcls_pkg::dp_cmd_t   cmd,
    input  tcls_pkg::dp_status_t status
);
    import tcls_pkg::*;

    state_t               state_reg;
    state_t               state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [DIV_CNT_W-1:0] div_cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 div_last;
    logic                 out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign div_last = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DIFF;
                end
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = status.go_div ? S_MUL1 : S_DONE;
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2     = 1'b1;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.div_last = div_last;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/tcls_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcls_dp
// Datapath: throttle counter, sample state, product and restoring divider.
// ----------------------------------------------------------------------------
module tcls_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tcls_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcls_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [tcls_pkg::TIME_W-1:0]   time_now,
    input  logic [tcls_pkg::TIME_W-1:0]   user_busy,
    input  logic [tcls_pkg::TIME_W-1:0]   system_busy,
    input  tcls_pkg::dp_cmd_t             cmd,
    output tcls_pkg::dp_status_t          status,
    output logic [tcls_pkg::PCT_W-1:0]    load_percent,
    output logic                          sampled
);
    import tcls_pkg::*;

    logic [INTERVAL_W-1:0] interval_reg;
    logic [DIVIDER_W-1:0]  divider_reg;

    logic [DIVIDER_W-1:0]  call_count_reg;
    logic                  have_base_reg;
    logic [TIME_W-1:0]     prev_time_reg;
    logic [TIME_W-1:0]     prev_busy_reg;
    logic [PCT_W-1:0]      held_reg;

    logic [TIME_W-1:0]     now_reg;
    logic [TIME_W-1:0]     busy_reg;
    logic [TIME_W-1:0]     elapsed_reg;
    logic [TIME_W-1:0]     delta_reg;
    logic                  pass_reg;
    logic                  sampled_reg;
    logic [PROD_W-1:0]     part_reg;
    logic [TIME_W-1:0]     rem_reg;
    logic [PCT_W-1:0]      low_reg;
    logic [PCT_W-1:0]      quo_reg;
    logic [PCT_W-1:0]      out_pct_reg;
    logic                  out_samp_reg;

    logic [DIVIDER_W-1:0]  count_inc;
    logic                  pass_now;
    logic                  take;
    logic                  saturate;
    logic [PROD_W-1:0]     prod_sum;
    logic [TIME_W:0]       rem_shift;
    logic [TIME_W:0]       rem_sub;
    logic                  rem_ge;

    assign count_inc = call_count_reg + 1'b1;
    assign pass_now  = (count_inc >= divider_reg);

    assign take     = pass_reg
                      && (!have_base_reg || (elapsed_reg > {32'd0, interval_reg}));
    assign saturate = (delta_reg >= elapsed_reg);
    assign status.go_div = take && have_base_reg && !saturate;

    // delta * 100 = delta * 96 + delta * 4, split over the mul1 and mul2 steps.
    assign prod_sum  = part_reg + {5'd0, delta_reg, 2'd0};

    assign rem_shift = {rem_reg, low_reg[PCT_W-1]};
    assign rem_sub   = rem_shift - {1'b0, elapsed_reg};
    assign rem_ge    = (rem_shift >= {1'b0, elapsed_reg});

    assign load_percent = out_pct_reg;
    assign sampled      = out_samp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg   <= SAMPLE_INTERVAL_RST;
            divider_reg    <= CALL_DIVIDER_RST;
            call_count_reg <= '0;
            have_base_reg  <= 1'b0;
            prev_time_reg  <= '0;
            prev_busy_reg  <= '0;
            held_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SAMPLE_INTERVAL: interval_reg <= cfg_data;
                    REG_CALL_DIVIDER:    divider_reg  <= cfg_data[DIVIDER_W-1:0];
                    default:             ;
                endcase
            end
            if (cmd.diff)
            begin
                call_count_reg <= pass_now ? (count_inc - divider_reg) : count_inc;
            end
            if (cmd.decide && take)
            begin
                prev_time_reg <= now_reg;
                prev_busy_reg <= busy_reg;
                have_base_reg <= 1'b1;
                if (have_base_reg && saturate)
                begin
                    held_reg <= PCT_FULL;
                end
            end
            if (cmd.div_last)
            begin
                held_reg <= {quo_reg[PCT_W-2:0], rem_ge};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            now_reg  <= time_now;
            busy_reg <= user_busy + system_busy;
        end
        if (cmd.diff)
        begin
            elapsed_reg <= now_reg - prev_time_reg;
            delta_reg   <= busy_reg - prev_busy_reg;
            pass_reg    <= pass_now;
        end
        if (cmd.decide)
        begin
            sampled_reg <= take;
        end
        if (cmd.mul1)
        begin
            part_reg <= {1'b0, delta_reg, 6'd0} + {2'd0, delta_reg, 5'd0};
        end
        if (cmd.mul2)
        begin
            // The upper part is already below the elapsed time because the
            // quotient is known to be under 128.
            rem_reg <= prod_sum[PROD_W-1:PCT_W];
            low_reg <= prod_sum[PCT_W-1:0];
            quo_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? rem_sub[TIME_W-1:0] : rem_shift[TIME_W-1:0];
            low_reg <= {low_reg[PCT_W-2:0], 1'b0};
            quo_reg <= {quo_reg[PCT_W-2:0], rem_ge};
        end
        if (cmd.out_load)
        begin
            out_pct_reg  <= held_reg;
            out_samp_reg <= sampled_reg;
        end
    end

endmodule

// ===== hdl/throttled_cpu_load_sampler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// throttled_cpu_load_sampler_unit
// Throttled CPU load sampler: turns collect calls into a load percentage.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Width  Contents
//  s_*      in   192    time_now, user_busy, system_busy (one collect call)
//  m_*      out  8 + 1  load_percent in tdata, sampled flag in tuser
//  cfg_*    in   2 + 32 register index and write data, no read-back
//
//  A word is taken only when the unit is idle. A call that does not take a
//  sample, or whose busy delta reaches the elapsed time, passes through
//  S_DIFF, S_DECIDE and S_DONE after acceptance; a call that computes a new
//  load also passes S_MUL1, S_MUL2 and the restoring divider loop in S_DIV
//  before S_DONE. The output register lets a new word be accepted while the
//  previous result still waits on m_tready; a stalled result only holds the
//  next one back at its final step. Reset is asynchronous, active low, and
//  restores the register defaults (interval 1000000, divider one) and clears
//  the state.
//
module throttled_cpu_load_sampler_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write port.
    input  logic                            cfg_we,
    input  logic [tcls_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcls_pkg::CFG_DATA_W-1:0] cfg_data,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [63:0] time_now, [127:64] user_busy, [191:128] system_busy
    input  logic [tcls_pkg::IN_DATA_W-1:0]  s_tdata,
    // Output stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [6:0] load_percent, [7] zero
    output logic [tcls_pkg::OUT_DATA_W-1:0] m_tdata,
    // [0] sampled
    output logic                            m_tuser
);
    import tcls_pkg::*;

    dp_cmd_t          cmd;
    dp_status_t       status;
    logic [PCT_W-1:0] load_percent;

    tcls_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    tcls_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .time_now     (s_tdata[TIME_W-1:0]),
        .user_busy    (s_tdata[2*TIME_W-1:TIME_W]),
        .system_busy  (s_tdata[3*TIME_W-1:2*TIME_W]),
        .cmd          (cmd),
        .status       (status),
        .load_percent (load_percent),
        .sampled      (m_tuser)
    );

    // The load fills the low seven bits; the top bit pads the byte.
    assign m_tdata = {1'b0, load_percent};

endmodule

// ===== hdl/tcls_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcls_chk
// Port-level checks for the throttled CPU load sampler.
// ----------------------------------------------------------------------------
module tcls_chk
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tcls_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                            m_tuser
);
    import tcls_pkg::*;

    // The load never exceeds full scale and the pad bit stays clear.
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[PCT_W-1:0] <= PCT_FULL) && !m_tdata[OUT_DATA_W-1])
        else $error("load percent out of range");

    // An accepted word is evaluated before the next: s_tready drops after the accept.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready)
        else $error("input accepted during evaluation");

    // A new result appears exactly as the unit returns to idle.
    a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) ##1 m_tvalid |-> $rose(s_tready))
        else $error("result issued outside the final step");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind throttled_cpu_load_sampler_unit tcls_chk u_tcls_chk
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
